// ===== src/dma_ring_occupancy_tracker_unit_macros.svh =====
// Assertion macros for the DMA ring occupancy tracker.
// Used by the top level; no other dependencies.
`ifndef DMA_RING_OCCUPANCY_TRACKER_UNIT_MACROS_SVH
`define DMA_RING_OCCUPANCY_TRACKER_UNIT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define DMA_ROT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("dma_rot: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DMA_ROT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dma_rot: sequence check failed");

`endif

// ===== src/dma_rot_pkg.sv =====
// Shared types and constants for the DMA ring occupancy tracker.
// No dependencies.
`timescale 1ns / 1ps

package dma_rot_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned BYTES_W = 19;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned THR_W   = 19;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(4096);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE    = 3'd0,
    CMD_POSITION = 3'd1,
    CMD_PAUSE    = 3'd2,
    CMD_RESUME   = 3'd3,
    CMD_FLUSH    = 3'd4,
    CMD_STATUS   = 3'd5
  } cmd_e;

  typedef struct packed {
    logic running;
    logic paused;
    logic start_stream;
    logic stream_halt;
    logic must_wait;
  } flags_t;

endpackage

// ===== src/dma_ring_occupancy_tracker_unit.sv =====
// Tracks a cyclic playback DMA ring: one command per transfer, one result per command.
// Top level. Depends on dma_rot_pkg, dma_rot_step and the assertion macro header.
`timescale 1ns / 1ps

// Each command is taken into an input register and, once the output register is free, applied
// to the ring state by a single pass of logic whose result lands in an output register. One
// command is accepted per cycle while the output is not stalled; the rate is set by the
// update loop on the write pointer, queued count and last position. A new command is taken
// while a finished result still waits, and in_stall_o rises only when both registers are
// full and the output is stalled. refill_threshold can be written at any idle time through
// the cfg channel, which is always ready. RING_BYTES must be a power of two.

`include "dma_ring_occupancy_tracker_unit_macros.svh"

module dma_ring_occupancy_tracker_unit
  import dma_rot_pkg::*;
#(
  parameter int unsigned RING_BYTES = 262144,
  localparam int unsigned PTR_W = $clog2(RING_BYTES),
  localparam int unsigned CNT_W = PTR_W + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [THR_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [BYTES_W-1:0] byte_count_i,
  input  logic [POS_W-1:0]   position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BYTES_W-1:0] accepted_bytes_o,
  output logic [PTR_W-1:0]   write_offset_o,
  output logic [CNT_W-1:0]   queue_fill_o,
  output logic               running_o,
  output logic               paused_o,
  output logic               start_stream_o,
  output logic               stream_halt_o,
  output logic               must_wait_o
);

  logic [THR_W-1:0]   thr_q;
  logic               in_valid_q;
  logic [CMD_W-1:0]   cmd_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [POS_W-1:0]   pos_q;
  logic [PTR_W-1:0]   wp_q, wp_d;
  logic [CNT_W-1:0]   qc_q, qc_d;
  logic [PTR_W-1:0]   lsp_q, lsp_d;
  logic               on_q, paused_q;
  logic               out_valid_q;
  logic [BYTES_W-1:0] acc_q, acc_d;
  logic [PTR_W-1:0]   off_q, off_d;
  flags_t             flags_q, flags_d;
  logic               out_free;
  logic               advance;
  logic               in_take;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign in_take     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q   <= command_i;
      bytes_q <= byte_count_i;
      pos_q   <= position_i;
    end
  end

  dma_rot_step #(
    .RING_BYTES(RING_BYTES)
  ) u_step (
    .command_i   (cmd_q),
    .byte_count_i(bytes_q),
    .position_i  (pos_q),
    .threshold_i (thr_q),
    .wp_i        (wp_q),
    .qc_i        (qc_q),
    .lsp_i       (lsp_q),
    .on_i        (on_q),
    .paused_i    (paused_q),
    .wp_o        (wp_d),
    .qc_o        (qc_d),
    .lsp_o       (lsp_d),
    .accepted_o  (acc_d),
    .offset_o    (off_d),
    .flags_o     (flags_d)
  );

  // ring state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      qc_q     <= '0;
      lsp_q    <= '0;
      on_q     <= 1'b0;
      paused_q <= 1'b0;
    end else if (advance) begin
      wp_q     <= wp_d;
      qc_q     <= qc_d;
      lsp_q    <= lsp_d;
      on_q     <= flags_d.running;
      paused_q <= flags_d.paused;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      acc_q   <= acc_d;
      off_q   <= off_d;
      flags_q <= flags_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_bytes_o = acc_q;
  assign write_offset_o   = off_q;
  assign queue_fill_o     = qc_q;
  assign running_o        = flags_q.running;
  assign paused_o         = flags_q.paused;
  assign start_stream_o   = flags_q.start_stream;
  assign stream_halt_o    = flags_q.stream_halt;
  assign must_wait_o      = flags_q.must_wait;

  `DMA_ROT_ASSERT(a_qc_bound, clk_i, rst_ni, qc_q <= CNT_W'(RING_BYTES))
  `DMA_ROT_ASSERT(a_pause_stops, clk_i, rst_ni, !(paused_q && on_q))
  `DMA_ROT_ASSERT(a_wp_aligned, clk_i, rst_ni, wp_q[1:0] == 2'b00)
  `DMA_ROT_ASSERT(a_acc_aligned, clk_i, rst_ni, !out_valid_q || acc_q[1:0] == 2'b00)
  `DMA_ROT_ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_q && out_stall_i, out_valid_q)

endmodule

// ===== src/dma_rot_step.sv =====
// Next-state and result logic for one tracker command.
// Depends on dma_rot_pkg.
`timescale 1ns / 1ps

module dma_rot_step
  import dma_rot_pkg::*;
#(
  parameter int unsigned RING_BYTES = 262144,
  localparam int unsigned PTR_W = $clog2(RING_BYTES),
  localparam int unsigned CNT_W = PTR_W + 1
) (
  input  logic [CMD_W-1:0]   command_i,
  input  logic [BYTES_W-1:0] byte_count_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [THR_W-1:0]   threshold_i,
  input  logic [PTR_W-1:0]   wp_i,
  input  logic [CNT_W-1:0]   qc_i,
  input  logic [PTR_W-1:0]   lsp_i,
  input  logic               on_i,
  input  logic               paused_i,
  output logic [PTR_W-1:0]   wp_o,
  output logic [CNT_W-1:0]   qc_o,
  output logic [PTR_W-1:0]   lsp_o,
  output logic [BYTES_W-1:0] accepted_o,
  output logic [PTR_W-1:0]   offset_o,
  output flags_t             flags_o
);

  localparam int unsigned CMP_W = (CNT_W > BYTES_W) ? CNT_W : BYTES_W;
  localparam logic [CMP_W-1:0] RING_C = CMP_W'(RING_BYTES);

  cmd_e             cmd;
  logic             in_ring;
  logic [PTR_W-1:0] pos_r;
  logic [PTR_W-1:0] sample;
  logic [PTR_W-1:0] diff;
  logic [CNT_W-1:0] consumed;
  logic             trk_ok;
  logic [CNT_W-1:0] qc_t;
  logic [PTR_W-1:0] lsp_t;
  logic [CMP_W-1:0] room;
  logic [CMP_W-1:0] ring_end;
  logic [CMP_W-1:0] bytes4;
  logic [CMP_W-1:0] chunk_a;
  logic [CMP_W-1:0] chunk_b;
  logic [CMP_W-1:0] chunk;
  logic             refill_wait;

  assign cmd     = cmd_e'(command_i);
  assign in_ring = (position_i[POS_W-1:PTR_W] == '0);
  assign pos_r   = position_i[PTR_W-1:0];
  assign sample  = in_ring ? pos_r : '0;

  // consumed bytes since last sample, wrapped and clamped to the queue
  assign diff     = pos_r - lsp_i;
  assign consumed = ({1'b0, diff} > qc_i) ? qc_i : {1'b0, diff};
  assign trk_ok   = on_i && in_ring;
  assign qc_t     = trk_ok ? (qc_i - consumed) : qc_i;
  assign lsp_t    = trk_ok ? pos_r : lsp_i;

  assign room     = RING_C - CMP_W'(qc_t);
  assign ring_end = RING_C - CMP_W'(wp_i);
  assign bytes4   = CMP_W'({byte_count_i[BYTES_W-1:2], 2'b00});
  assign chunk_a  = (bytes4 < room) ? bytes4 : room;
  assign chunk_b  = (chunk_a < ring_end) ? chunk_a : ring_end;
  assign chunk    = {chunk_b[CMP_W-1:2], 2'b00};

  assign refill_wait = on_i && (qc_t != '0) && (room < CMP_W'(threshold_i));

  always_comb begin
    wp_o       = wp_i;
    qc_o       = qc_i;
    lsp_o      = lsp_i;
    accepted_o = '0;
    flags_o    = '{running: on_i, paused: paused_i, default: 1'b0};
    unique case (cmd)
      CMD_WRITE: begin
        if (bytes4 != '0) begin
          if (paused_i) begin
            flags_o.must_wait = 1'b1;
          end else begin
            qc_o  = qc_t;
            lsp_o = lsp_t;
            if (refill_wait) begin
              flags_o.must_wait = 1'b1;
            end else begin
              wp_o       = wp_i + chunk[PTR_W-1:0];
              qc_o       = qc_t + chunk[CNT_W-1:0];
              accepted_o = chunk[BYTES_W-1:0];
              if (!on_i) begin
                lsp_o                = sample;
                flags_o.running      = 1'b1;
                flags_o.start_stream = 1'b1;
              end
            end
          end
        end
      end
      CMD_POSITION, CMD_STATUS: begin
        qc_o  = qc_t;
        lsp_o = lsp_t;
      end
      CMD_PAUSE: begin
        if (!paused_i) begin
          if (on_i) begin
            qc_o                = qc_t;
            lsp_o               = lsp_t;
            flags_o.running     = 1'b0;
            flags_o.stream_halt = 1'b1;
          end
          flags_o.paused = 1'b1;
        end
      end
      CMD_RESUME: begin
        if (paused_i) begin
          flags_o.paused = 1'b0;
          if (qc_i != '0) begin
            lsp_o                = sample;
            flags_o.running      = 1'b1;
            flags_o.start_stream = 1'b1;
          end
        end
      end
      CMD_FLUSH: begin
        flags_o.stream_halt = on_i;
        flags_o.running     = 1'b0;
        flags_o.paused      = 1'b0;
        wp_o                = {sample[PTR_W-1:2], 2'b00};
        qc_o                = '0;
        lsp_o               = sample;
      end
      default: begin
        // unused codes report the state untouched
      end
    endcase
  end

  assign offset_o = (cmd == CMD_WRITE) ? wp_i : wp_o;

endmodule
